// ===== src/audio_downmix_frame_fifo_core_assert.svh =====
// Assertion macros shared by the frame FIFO modules.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef AUDIO_DOWNMIX_FRAME_FIFO_CORE_ASSERT_SVH
`define AUDIO_DOWNMIX_FRAME_FIFO_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define ADFQ_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adfq assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ADFQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adfq assertion failed");

`else

`define ADFQ_ASSERT_IMPLIES(lbl, ante, cons)
`define ADFQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/adfq_pkg.sv =====
`default_nettype none

package adfq_pkg;

   // Buffer geometry.
   localparam int FIFO_FRAMES   = 22;
   localparam int FRAME_SAMPLES = 256;
   localparam int MAX_CHANNELS  = 6;
   localparam int WORDS_STEREO  = 2;
   localparam int STORE_DEPTH   = FIFO_FRAMES * FRAME_SAMPLES * MAX_CHANNELS;
   localparam int CAP_STEREO    = FIFO_FRAMES * FRAME_SAMPLES * WORDS_STEREO;
   localparam int NEED_STEREO   = FRAME_SAMPLES * WORDS_STEREO;
   localparam int NEED_SIX      = FRAME_SAMPLES * MAX_CHANNELS;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int STEP_W = $clog2(MAX_CHANNELS);

   // Sample and arithmetic widths.
   localparam int SAMPLE_W = 16;
   localparam int FILL_W   = 16;
   localparam int GAIN_W   = 17;
   localparam int OP_W     = 20;
   localparam int PROD_W   = OP_W + GAIN_W + 1;
   localparam int SHIFT    = 18;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_DOWNMIX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_GAIN    = 1'b1;
   localparam logic [GAIN_W-1:0]    GAIN_UNITY      = 17'd65536;

   // Item kinds.
   localparam logic KIND_SUBMIT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Response queue.
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic                       kind;
      logic                       frame_start;
      logic signed [SAMPLE_W-1:0] ch0;
      logic signed [SAMPLE_W-1:0] ch1;
      logic signed [SAMPLE_W-1:0] ch2;
      logic signed [SAMPLE_W-1:0] ch3;
      logic signed [SAMPLE_W-1:0] ch4;
      logic signed [SAMPLE_W-1:0] ch5;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       underrun;
      logic                       frame_dropped;
      logic [FILL_W-1:0]          fill_words;
   } rsp_type;

   // Status of the gain unit toward the control logic.
   typedef struct packed {
      logic                busy;
      logic                wr_valid;
      logic [SAMPLE_W-1:0] word;
   } mix_out_type;

endpackage

`default_nettype wire

// ===== src/adfq_store.sv =====
`default_nettype none

module adfq_store import adfq_pkg::*; (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic                we,
   input  wire logic [ADDR_W-1:0]   addr,
   input  wire logic [SAMPLE_W-1:0] wdata,
   output logic      [SAMPLE_W-1:0] rdata
);

   logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff;

   // Single-port sample memory with a registered read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/adfq_mix.sv =====
`default_nettype none

`include "audio_downmix_frame_fifo_core_assert.svh"

module adfq_mix import adfq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic              stereo,
   input  wire logic [GAIN_W-1:0] gain,
   input  wire req_type           req,
   output mix_out_type            mix_out
);

   localparam logic signed [PROD_W:0]   ROUND   = (PROD_W + 1)'(1) <<< (SHIFT - 1);
   localparam int                       Q_W     = PROD_W + 1 - SHIFT;
   localparam logic signed [Q_W-1:0]    SAT_MAX = Q_W'(32767);
   localparam logic signed [Q_W-1:0]    SAT_MIN = -Q_W'(32768);

   logic signed [OP_W-1:0]   op_ff [MAX_CHANNELS];
   logic signed [OP_W-1:0]   op_in [MAX_CHANNELS];
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [STEP_W-1:0]        last_ff, last_in;
   logic                     active_ff, active_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_valid_ff, prod_valid_in;
   logic signed [OP_W-1:0]   op_sel;
   logic signed [OP_W-1:0]   c [MAX_CHANNELS];

   // Round to nearest with ties upward, then saturate to a sample word.
   function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] s;
      logic signed [Q_W-1:0]  q;
      s = (PROD_W + 1)'(p) + ROUND;
      q = Q_W'(s >>> SHIFT);
      if (q > SAT_MAX) begin
         q = SAT_MAX;
      end else if (q < SAT_MIN) begin
         q = SAT_MIN;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   // Channels scaled by four so both modes share one final shift.
   assign c[0] = OP_W'(req.ch0);
   assign c[1] = OP_W'(req.ch1);
   assign c[2] = OP_W'(req.ch2);
   assign c[3] = OP_W'(req.ch3);
   assign c[4] = OP_W'(req.ch4);
   assign c[5] = OP_W'(req.ch5);

   always_comb begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         op_in[i] = op_ff[i];
      end
      if (load) begin
         if (stereo) begin
            op_in[0] = (c[0] <<< 2) + (c[2] <<< 1) + c[2] + (c[4] <<< 2);
            op_in[1] = (c[1] <<< 2) + (c[2] <<< 1) + c[2] + (c[5] <<< 2);
         end else begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
               op_in[i] = c[i] <<< 2;
            end
         end
      end
   end

   // One product per cycle, walking through the words of the item.
   assign op_sel  = op_ff[step_ff];
   assign prod_in = PROD_W'(op_sel) * PROD_W'($signed({1'b0, gain}));

   always_comb begin
      step_in       = step_ff;
      last_in       = last_ff;
      active_in     = active_ff;
      prod_valid_in = active_ff;
      if (load) begin
         step_in   = '0;
         last_in   = stereo ? STEP_W'(WORDS_STEREO - 1) : STEP_W'(MAX_CHANNELS - 1);
         active_in = 1'b1;
      end else if (active_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == last_ff) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         prod_valid_ff <= prod_valid_in;
      end
      step_ff <= step_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         op_ff[i] <= op_in[i];
      end
   end

   assign mix_out.busy     = active_ff | prod_valid_ff;
   assign mix_out.wr_valid = prod_valid_ff;
   assign mix_out.word     = round_sat(prod_ff);

   `ADFQ_ASSERT_IMPLIES(a_step_bound, active_ff, step_ff <= last_ff)
   `ADFQ_ASSERT_NEXT(a_load_starts, load, active_ff)

endmodule

`default_nettype wire

// ===== src/adfq_rsp_queue.sv =====
`default_nettype none

`include "audio_downmix_frame_fifo_core_assert.svh"

module adfq_rsp_queue import adfq_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rsp_type              push_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   output logic      [RSP_CNT_W-1:0] count
);

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid & ~rsp_stall;
   assign count       = count_ff;

   // Pointer and occupancy update.
   always_comb begin
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   `ADFQ_ASSERT_IMPLIES(a_no_overflow, push && !pop, count_ff < RSP_CNT_W'(RSP_DEPTH))

endmodule

`default_nettype wire

// ===== src/audio_downmix_frame_fifo_core.sv =====
// Channel   Direction  Handshake           Word
// req       in         req_valid/stall     req_type: one sample time or one read
// rsp       out        rsp_valid/stall     rsp_type: one result per request word
// csr       in         csr_valid/ready     index and data of a register write
//
// A read word uses the single memory port once; reads follow back to back while
// responses drain; each result is registered in s1 and then in the response queue.
// A stored submit word holds the port for its writes through the one shared
// multiplier: two words in stereo mode, six in six-channel mode; a dropped one writes none.
// Reset is synchronous and needs no clearing pass; the store is never read unwritten.
// A two-word response queue lets a new request word enter while a result waits.
`default_nettype none

`include "audio_downmix_frame_fifo_core_assert.svh"

module audio_downmix_frame_fifo_core import adfq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                  stereo_ff, stereo_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [ADDR_W-1:0]     rp_ff, rp_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic                  admitted_ff, admitted_in;
   logic [ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic                  s1_valid_ff;
   logic                  s1_from_mem_ff, s1_from_mem_in;
   rsp_type               s1_word_ff, s1_word_in;

   logic [CNT_W-1:0]      cap;
   logic [CNT_W-1:0]      free_words;
   logic [CNT_W-1:0]      need_frame;
   logic [CNT_W-1:0]      words_now;
   logic [CNT_W:0]        tail_sum;
   logic [ADDR_W:0]       rp_next;
   logic                  accept;
   logic                  is_read;
   logic                  rd_issue;
   logic                  store_now;
   logic                  admit_now;
   logic                  csr_write;
   logic                  pop;
   logic [RSP_CNT_W:0]    occupancy;
   logic [RSP_CNT_W-1:0]  q_count;
   logic [SAMPLE_W-1:0]   mem_rdata;
   logic                  mem_en;
   logic [ADDR_W-1:0]     mem_addr;
   rsp_type               push_word;
   mix_out_type           mix_out;

   // Capacity and frame size follow the current mode.
   assign cap        = stereo_ff ? CNT_W'(CAP_STEREO) : CNT_W'(STORE_DEPTH);
   assign need_frame = stereo_ff ? CNT_W'(NEED_STEREO) : CNT_W'(NEED_SIX);
   assign words_now  = stereo_ff ? CNT_W'(WORDS_STEREO) : CNT_W'(MAX_CHANNELS);
   assign free_words = cap - used_ff;

   // Accept only with the memory port free and room for the result.
   assign pop       = rsp_valid & ~rsp_stall;
   assign occupancy = (RSP_CNT_W + 1)'(q_count) + (RSP_CNT_W + 1)'(s1_valid_ff)
                      - (RSP_CNT_W + 1)'(pop);
   assign req_stall = mix_out.busy | (occupancy >= (RSP_CNT_W + 1)'(RSP_DEPTH));
   assign accept    = req_valid & ~req_stall;
   assign is_read   = req_payload.kind == KIND_READ;

   // Admission is decided at the first sample time of a frame.
   assign admit_now = req_payload.frame_start ? (free_words >= need_frame) : admitted_ff;
   assign store_now = accept & ~is_read & admit_now & (free_words >= words_now);
   assign rd_issue  = accept & is_read & (used_ff != '0);

   assign tail_sum = (CNT_W + 1)'(rp_ff) + (CNT_W + 1)'(used_ff);
   assign rp_next  = (ADDR_W + 1)'(rp_ff) + 1'b1;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Pointer, fill, admission, mode and gain state.
   always_comb begin
      stereo_in   = stereo_ff;
      gain_in     = gain_ff;
      rp_in       = rp_ff;
      used_in     = used_ff;
      admitted_in = admitted_ff;
      wr_addr_in  = wr_addr_ff;
      if (mix_out.wr_valid) begin
         wr_addr_in = ((ADDR_W + 1)'(wr_addr_ff) + 1'b1 >= (ADDR_W + 1)'(cap))
                      ? '0 : wr_addr_ff + 1'b1;
      end
      if (accept && !is_read) begin
         admitted_in = admit_now;
         if (store_now) begin
            used_in    = used_ff + words_now;
            wr_addr_in = (tail_sum >= (CNT_W + 1)'(cap))
                         ? ADDR_W'(tail_sum - (CNT_W + 1)'(cap)) : ADDR_W'(tail_sum);
         end
      end
      if (rd_issue) begin
         used_in = used_ff - 1'b1;
         rp_in   = (rp_next >= (ADDR_W + 1)'(cap)) ? '0 : ADDR_W'(rp_next);
      end
      if (csr_write) begin
         case (csr_index)
            CSR_IDX_DOWNMIX: begin
               stereo_in   = csr_wdata[0];
               rp_in       = '0;
               used_in     = '0;
               admitted_in = 1'b0;
            end
            CSR_IDX_GAIN: begin
               gain_in = csr_wdata;
            end
            default: begin
               gain_in = gain_ff;
            end
         endcase
      end
   end

   // Result fields known at acceptance; the sample follows from memory.
   always_comb begin
      s1_word_in               = s1_word_ff;
      s1_from_mem_in           = s1_from_mem_ff;
      if (accept) begin
         s1_word_in.sample_out    = '0;
         s1_word_in.underrun      = is_read & (used_ff == '0);
         s1_word_in.frame_dropped = ~is_read & ~store_now;
         s1_word_in.fill_words    = FILL_W'(used_in);
         s1_from_mem_in           = rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff   <= 1'b1;
         gain_ff     <= GAIN_UNITY;
         rp_ff       <= '0;
         used_ff     <= '0;
         admitted_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         stereo_ff   <= stereo_in;
         gain_ff     <= gain_in;
         rp_ff       <= rp_in;
         used_ff     <= used_in;
         admitted_ff <= admitted_in;
         s1_valid_ff <= accept;
      end
      wr_addr_ff     <= wr_addr_in;
      s1_word_ff     <= s1_word_in;
      s1_from_mem_ff <= s1_from_mem_in;
   end

   always_comb begin
      push_word            = s1_word_ff;
      push_word.sample_out = s1_from_mem_ff ? $signed(mem_rdata) : '0;
   end

   // Memory port: writes from the gain unit, otherwise reads at the read pointer.
   assign mem_en   = mix_out.wr_valid | rd_issue;
   assign mem_addr = mix_out.wr_valid ? wr_addr_ff : rp_ff;

   adfq_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .load    (store_now),
      .stereo  (stereo_ff),
      .gain    (gain_ff),
      .req     (req_payload),
      .mix_out (mix_out)
   );

   adfq_store u_store (
      .clock (clock),
      .en    (mem_en),
      .we    (mix_out.wr_valid),
      .addr  (mem_addr),
      .wdata (mix_out.word),
      .rdata (mem_rdata)
   );

   adfq_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (s1_valid_ff),
      .push_word   (push_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .count       (q_count)
   );

   `ADFQ_ASSERT_IMPLIES(a_port_excl, mix_out.wr_valid, !rd_issue)
   `ADFQ_ASSERT_IMPLIES(a_used_cap, 1'b1, used_ff <= cap)
   `ADFQ_ASSERT_IMPLIES(a_rp_cap, 1'b1, (ADDR_W + 1)'(rp_ff) < (ADDR_W + 1)'(cap))

endmodule

`default_nettype wire
